// ===== design/c3d_pkg.sv =====
// ============================================================================
// c3d_pkg
// Shared types and constants for the streaming 3x3x3 convolution block.
// ============================================================================

package c3d_pkg;

    // Kernel geometry
    localparam int SIDE  = 3;
    localparam int ROWS  = SIDE * SIDE;
    localparam int TAPS  = SIDE * SIDE * SIDE;

    // Datapath widths
    localparam int VOXEL_W   = 16;
    localparam int COEF_W    = 13;
    localparam int PROD_W    = VOXEL_W + COEF_W;
    localparam int GROUP_W   = PROD_W + 2;
    localparam int PART_W    = PROD_W + 4;
    localparam int ACC_W     = PROD_W + 5;
    localparam int FRAC_BITS = 10;
    localparam int QUO_W     = ACC_W - FRAC_BITS;
    localparam int OUT_W     = 24;

    // Volume dimension register layout
    localparam int DIMS_W    = 24;
    localparam int X_FIELD_W = 6;
    localparam int Y_FIELD_W = 6;
    localparam int Z_FIELD_W = 12;
    localparam int ZS_W      = Z_FIELD_W + 1;
    localparam logic [DIMS_W-1:0] DIMS_RESET = 24'd29127;

    // Configuration port
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 52;
    localparam int COEFS_PER_WORD = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VOLUME_DIMS,
        REG_MASK_0,
        REG_MASK_1,
        REG_MASK_2,
        REG_MASK_3,
        REG_MASK_4,
        REG_MASK_5,
        REG_MASK_6
    } cfg_reg_t;

    typedef logic signed [VOXEL_W-1:0] voxel_t;
    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [GROUP_W-1:0] group_t;
    typedef logic signed [PART_W-1:0]  part_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic signed [QUO_W-1:0]   quo_t;
    typedef logic signed [OUT_W-1:0]   result_t;

    localparam result_t OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam result_t OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // Delay line control
    typedef struct packed {
        logic restart;
        logic advance;
    } dl_ctrl_t;

endpackage

// ===== design/conv3d_3x3x3_stream_top.sv =====
// ============================================================================
// conv3d_3x3x3_stream_top
// Zero-padded 3x3x3 convolution over a raster-streamed volume.
// ============================================================================
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------
//  sample   | sample_valid/sample_stall | voxel (s16)
//  result   | result_valid/result_stall | value (s24), saturated, last
//  config   | cfg_valid/cfg_ready       | cfg_index (3b), cfg_data (52b)
//
//  Unstalled, one voxel transfer per cycle is sustained; the delay-line
//  memories each do one write and one prefetch read per cycle, so they
//  set that figure. The result for a window follows the transfer of the
//  voxel that completes it through the window register, products, two
//  adder levels, final add and result register.
//  Reset clears positions, pointers, pipeline valids and coefficients and
//  loads an 8x8x8 volume. The delay memories are not cleared: window taps
//  that fall outside the current volume are forced to zero instead.
//  A stalled result holds in the output register while upstream stages keep
//  filling; sample_stall rises only once every stage holds an item.
//  Writing volume_dims restarts the raster position and the delay pointers.
//
// ============================================================================

module conv3d_3x3x3_stream_top #(
    parameter int MAX_X = 64,
    parameter int MAX_Y = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // sample channel
    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  c3d_pkg::voxel_t                   voxel,
    // result channel
    output logic                              result_valid,
    input  logic                              result_stall,
    output c3d_pkg::result_t                  value,
    output logic                              saturated,
    output logic                              last,
    // configuration channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [c3d_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [c3d_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import c3d_pkg::*;

    // ------------------------------------------------------------------------
    // Size limits and derived storage
    // ------------------------------------------------------------------------
    localparam int X_FIELD_MAX = 1 << X_FIELD_W;
    localparam int Y_FIELD_MAX = 1 << Y_FIELD_W;
    localparam int XS_MAX = (MAX_X < X_FIELD_MAX) ? MAX_X : X_FIELD_MAX;
    localparam int YS_MAX = (MAX_Y < Y_FIELD_MAX) ? MAX_Y : Y_FIELD_MAX;
    localparam int XW = $clog2(XS_MAX + 1);
    localparam int YW = $clog2(YS_MAX + 1);
    localparam int XF1_W = X_FIELD_W + 1;
    localparam int YF1_W = Y_FIELD_W + 1;

    // One extended line, and the gap from the end of the second line back
    // to the start of the previous plane
    localparam int LINE_DEPTH = XS_MAX + 1;
    localparam int LINE_LW    = $clog2(LINE_DEPTH) + 1;
    localparam int GAP_RAW    = (YS_MAX - 1) * LINE_DEPTH;
    localparam int GAP_DEPTH  = (GAP_RAW < 2) ? 2 : GAP_RAW;
    localparam int GAP_LW     = $clog2(GAP_DEPTH) + 1;

    localparam int X_RAW_RST = int'(DIMS_RESET[X_FIELD_W-1:0]) + 1;
    localparam int Y_RAW_RST = int'(DIMS_RESET[X_FIELD_W +: Y_FIELD_W]) + 1;
    localparam int XS_RST  = (X_RAW_RST > XS_MAX) ? XS_MAX : X_RAW_RST;
    localparam int YS_RST  = (Y_RAW_RST > YS_MAX) ? YS_MAX : Y_RAW_RST;
    localparam int ZS_RST  = int'(DIMS_RESET[X_FIELD_W + Y_FIELD_W +: Z_FIELD_W]) + 1;
    localparam int LE_RST  = XS_RST + 1;
    localparam int GAP_RST = (YS_RST - 1) * LE_RST;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic                  cfg_we;
    logic                  restart;
    logic [XW-1:0]         xs_reg;
    logic [YW-1:0]         ys_reg;
    logic [ZS_W-1:0]       zs_reg;
    logic [LINE_LW-1:0]    le_reg;
    logic [GAP_LW-1:0]     gap_reg;
    coef_t                 coef_reg [TAPS];

    logic [XF1_W-1:0]      x_raw;
    logic [YF1_W-1:0]      y_raw;
    logic [XW-1:0]         xs_dec;
    logic [YW-1:0]         ys_dec;
    logic [ZS_W-1:0]       zs_dec;
    logic [LINE_LW-1:0]    le_dec;
    logic [YW+LINE_LW-1:0] gap_prod;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign restart   = cfg_we && (cfg_index == REG_VOLUME_DIMS);

    // Decode the dimension word: clamp x and y to the line buffer size
    always_comb
    begin
        x_raw    = {1'b0, cfg_data[X_FIELD_W-1:0]} + XF1_W'(1);
        y_raw    = {1'b0, cfg_data[X_FIELD_W +: Y_FIELD_W]} + YF1_W'(1);
        xs_dec   = (x_raw > XF1_W'(XS_MAX)) ? XW'(XS_MAX) : XW'(x_raw);
        ys_dec   = (y_raw > YF1_W'(YS_MAX)) ? YW'(YS_MAX) : YW'(y_raw);
        zs_dec   = {1'b0, cfg_data[X_FIELD_W + Y_FIELD_W +: Z_FIELD_W]} + ZS_W'(1);
        le_dec   = LINE_LW'(xs_dec) + LINE_LW'(1);
        gap_prod = (YW + LINE_LW)'(ys_dec - YW'(1)) * (YW + LINE_LW)'(le_dec);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xs_reg  <= XW'(XS_RST);
            ys_reg  <= YW'(YS_RST);
            zs_reg  <= ZS_W'(ZS_RST);
            le_reg  <= LINE_LW'(LE_RST);
            gap_reg <= GAP_LW'(GAP_RST);
            for (int k = 0; k < TAPS; k++)
            begin
                coef_reg[k] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_VOLUME_DIMS)
            begin
                xs_reg  <= xs_dec;
                ys_reg  <= ys_dec;
                zs_reg  <= zs_dec;
                le_reg  <= le_dec;
                gap_reg <= GAP_LW'(gap_prod);
            end
            // Four coefs per mask word (last: three), lowest k in bits 12:0
            for (int k = 0; k < TAPS; k++)
            begin
                if (cfg_index == CFG_IDX_W'(int'(REG_MASK_0) + k / COEFS_PER_WORD))
                begin
                    coef_reg[k] <= cfg_data[COEF_W * (k % COEFS_PER_WORD) +: COEF_W];
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline handshake: each stage takes a new item when empty or draining
    // ------------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, result_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
    logic accept;

    assign rdy6 = !result_valid_reg || !result_stall;
    assign rdy5 = !v5_reg || rdy6;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign sample_stall = !rdy1;
    assign accept       = sample_valid && rdy1;

    // ------------------------------------------------------------------------
    // Raster position over the extended grid
    // ------------------------------------------------------------------------
    logic [XW-1:0]   pos_x_reg;
    logic [YW-1:0]   pos_y_reg;
    logic [ZS_W-1:0] pos_z_reg;
    logic            x_edge, y_edge, z_edge;
    logic            pad, emit, is_last;
    voxel_t          sample;

    assign x_edge  = (pos_x_reg >= xs_reg);
    assign y_edge  = (pos_y_reg >= ys_reg);
    assign z_edge  = (pos_z_reg >= zs_reg);
    assign pad     = x_edge || y_edge || z_edge;
    assign emit    = (pos_x_reg != '0) && (pos_y_reg != '0) && (pos_z_reg != '0);
    assign is_last = (pos_x_reg == xs_reg) && (pos_y_reg == ys_reg)
                     && (pos_z_reg == zs_reg);
    // Zero the voxel on the pad edge
    assign sample  = pad ? '0 : voxel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
        end
        else if (restart)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
        end
        else if (accept)
        begin
            if (is_last)
            begin
                pos_x_reg <= '0;
                pos_y_reg <= '0;
                pos_z_reg <= '0;
            end
            else if (x_edge)
            begin
                pos_x_reg <= '0;
                if (y_edge)
                begin
                    pos_y_reg <= '0;
                    pos_z_reg <= pos_z_reg + ZS_W'(1);
                end
                else
                begin
                    pos_y_reg <= pos_y_reg + YW'(1);
                end
            end
            else
            begin
                pos_x_reg <= pos_x_reg + XW'(1);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Line and plane delays: row r = 3*dz + dy lags the input by dz planes
    // and dy lines. Chain: line, line, gap, line, line, gap, line, line.
    // ------------------------------------------------------------------------
    dl_ctrl_t dl_ctrl;
    voxel_t   dl_in  [ROWS-1];
    voxel_t   dl_out [ROWS-1];
    voxel_t   row_cur   [ROWS];
    voxel_t   prev1_reg [ROWS];
    voxel_t   prev2_reg [ROWS];

    assign dl_ctrl.restart = restart;
    assign dl_ctrl.advance = accept;

    for (genvar i = 0; i < ROWS - 1; i++)
    begin : g_delay
        if (i == 0)
        begin : g_first
            assign dl_in[i] = sample;
        end
        else
        begin : g_next
            assign dl_in[i] = dl_out[i-1];
        end

        if ((i % SIDE) == SIDE - 1)
        begin : g_gap
            c3d_delay_line #(
                .DEPTH (GAP_DEPTH)
            ) u_gap (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (dl_ctrl),
                .len   (gap_reg),
                .din   (dl_in[i]),
                .dout  (dl_out[i])
            );
        end
        else
        begin : g_line
            c3d_delay_line #(
                .DEPTH (LINE_DEPTH)
            ) u_line (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (dl_ctrl),
                .len   (le_reg),
                .din   (dl_in[i]),
                .dout  (dl_out[i])
            );
        end

        assign row_cur[i+1] = dl_out[i];
    end

    assign row_cur[0] = sample;

    // Hold the two previous samples of every row for the x taps
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                prev1_reg[r] <= row_cur[r];
                prev2_reg[r] <= prev1_reg[r];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: window register, taps outside the volume forced to zero
    // ------------------------------------------------------------------------
    logic [SIDE-1:0] xv, yv, zv;
    voxel_t          tap_next [TAPS];
    voxel_t          tap_reg  [TAPS];
    logic            last1_reg;

    // Index 2 is the current line/plane/column, index 0 the oldest
    assign xv[2] = !x_edge;
    assign xv[1] = (pos_x_reg != '0);
    assign xv[0] = (pos_x_reg > XW'(1));
    assign yv[2] = !y_edge;
    assign yv[1] = (pos_y_reg != '0);
    assign yv[0] = (pos_y_reg > YW'(1));
    assign zv[2] = !z_edge;
    assign zv[1] = (pos_z_reg != '0);
    assign zv[0] = (pos_z_reg > ZS_W'(1));

    always_comb
    begin
        int     r;
        int     dx;
        voxel_t v;
        for (int a = 0; a < SIDE; a++)
        begin
            for (int b = 0; b < SIDE; b++)
            begin
                for (int c = 0; c < SIDE; c++)
                begin
                    r  = (SIDE - 1 - a) * SIDE + (SIDE - 1 - b);
                    dx = SIDE - 1 - c;
                    if (dx == 0)
                    begin
                        v = row_cur[r];
                    end
                    else if (dx == 1)
                    begin
                        v = prev1_reg[r];
                    end
                    else
                    begin
                        v = prev2_reg[r];
                    end
                    tap_next[a * SIDE * SIDE + b * SIDE + c] =
                        (zv[a] && yv[b] && xv[c]) ? v : '0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stages 2 to 5: products, sums of three, sums of nine, total
    // ------------------------------------------------------------------------
    prod_t  prod_reg  [TAPS];
    group_t grp_reg   [ROWS];
    part_t  part_reg  [SIDE];
    acc_t   acc_reg;
    logic   last2_reg, last3_reg, last4_reg, last5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            v4_reg           <= 1'b0;
            v5_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= accept && emit;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
            if (rdy6)
            begin
                result_valid_reg <= v5_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            tap_reg   <= tap_next;
            last1_reg <= is_last;
        end
        if (rdy2 && v1_reg)
        begin
            for (int k = 0; k < TAPS; k++)
            begin
                prod_reg[k] <= PROD_W'(tap_reg[k]) * PROD_W'(coef_reg[k]);
            end
            last2_reg <= last1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            for (int g = 0; g < ROWS; g++)
            begin
                grp_reg[g] <= GROUP_W'(prod_reg[SIDE * g])
                              + GROUP_W'(prod_reg[SIDE * g + 1])
                              + GROUP_W'(prod_reg[SIDE * g + 2]);
            end
            last3_reg <= last2_reg;
        end
        if (rdy4 && v3_reg)
        begin
            for (int p = 0; p < SIDE; p++)
            begin
                part_reg[p] <= PART_W'(grp_reg[SIDE * p])
                               + PART_W'(grp_reg[SIDE * p + 1])
                               + PART_W'(grp_reg[SIDE * p + 2]);
            end
            last4_reg <= last3_reg;
        end
        if (rdy5 && v4_reg)
        begin
            acc_reg   <= ACC_W'(part_reg[0]) + ACC_W'(part_reg[1]) + ACC_W'(part_reg[2]);
            last5_reg <= last4_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 6: floor shift, saturate, result register
    // ------------------------------------------------------------------------
    quo_t    quo;
    result_t value_next;
    logic    sat_next;
    result_t value_reg;
    logic    saturated_reg;
    logic    last_reg;

    assign quo = acc_reg[ACC_W-1:FRAC_BITS];

    always_comb
    begin
        if (quo > QUO_W'(OUT_MAX))
        begin
            value_next = OUT_MAX;
            sat_next   = 1'b1;
        end
        else if (quo < QUO_W'(OUT_MIN))
        begin
            value_next = OUT_MIN;
            sat_next   = 1'b1;
        end
        else
        begin
            value_next = quo[OUT_W-1:0];
            sat_next   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy6 && v5_reg)
        begin
            value_reg     <= value_next;
            saturated_reg <= sat_next;
            last_reg      <= last5_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign value        = value_reg;
    assign saturated    = saturated_reg;
    assign last         = last_reg;

endmodule

// ===== design/c3d_delay_line.sv =====
// ============================================================================
// c3d_delay_line
// Programmable-length sample delay built on a circular buffer memory.
// ============================================================================

module c3d_delay_line #(
    parameter int DEPTH = 2,
    localparam int PW = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  c3d_pkg::dl_ctrl_t ctrl,
    input  logic [PW:0]       len,
    input  c3d_pkg::voxel_t   din,
    output c3d_pkg::voxel_t   dout
);
    import c3d_pkg::*;

    voxel_t        mem [DEPTH];
    logic [PW-1:0] ptr_reg;
    logic [PW-1:0] ptr_next;
    logic [PW:0]   ptr_inc;
    voxel_t        mem_rd_reg;
    voxel_t        byp_reg;
    logic          byp_sel_reg;

    // Wrap the pointer at the programmed length
    always_comb
    begin
        ptr_inc = {1'b0, ptr_reg} + (PW + 1)'(1);
        if (ctrl.restart)
        begin
            ptr_next = '0;
        end
        else if (ctrl.advance)
        begin
            ptr_next = (ptr_inc >= len) ? '0 : ptr_inc[PW-1:0];
        end
        else
        begin
            ptr_next = ptr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg     <= '0;
            byp_sel_reg <= 1'b0;
        end
        else
        begin
            ptr_reg     <= ptr_next;
            byp_sel_reg <= ctrl.advance && (ptr_next == ptr_reg);
        end
    end

    // Write the new sample, prefetch the slot used at the next transfer
    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            mem[ptr_reg] <= din;
        end
        mem_rd_reg <= mem[ptr_next];
    end

    // Forward the sample just written when the line is one slot long
    always_ff @(posedge clk)
    begin
        byp_reg <= din;
    end

    assign dout = (len == '0) ? din : (byp_sel_reg ? byp_reg : mem_rd_reg);

endmodule

// ===== design/c3d_checker.sv =====
// ============================================================================
// c3d_checker
// Port-level checks on the streaming 3x3x3 convolution block.
// ============================================================================

module c3d_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             sample_stall,
    input logic             result_valid,
    input logic             result_stall,
    input c3d_pkg::result_t value,
    input logic             saturated,
    input logic             last
);
    import c3d_pkg::*;

    // A stalled result holds until its transfer
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(value) && $stable(saturated) && $stable(last))
        else $error("stalled result changed");

    // A clipped value sits on one of the two limits
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && saturated |-> (value == OUT_MAX) || (value == OUT_MIN))
        else $error("saturated flag without limit value");

    // An empty result register means the pipeline can take a sample
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !sample_stall)
        else $error("sample stalled with empty result register");

    // No result and no sample stall while in reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !result_valid && !sample_stall)
        else $error("activity during reset");

endmodule

bind conv3d_3x3x3_stream_top c3d_checker u_c3d_checker (.*);
